FILE: rtl/core/assert_macros.svh
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/spq_pkg.sv
package spq_pkg;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_SCAN,
    S_PUSH_HEAD,
    S_POP_SCAN,
    S_DONE
  } spq_state_t;

  typedef struct packed {
    logic        done;
    spq_status_t status;
  } spq_res_t;

endpackage

FILE: rtl/core/spq_mem.sv
module spq_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata_d,
  input  logic [PRIO_WIDTH-1:0]    wdata_p,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata_d,
  output logic [PRIO_WIDTH-1:0]    rdata_p
);

  logic [DATA_WIDTH-1:0] mem_data_r [DEPTH];
  logic [PRIO_WIDTH-1:0] mem_prio_r [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [PRIO_WIDTH-1:0] rd_prio_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_data_r[waddr] <= wdata_d;
      mem_prio_r[waddr] <= wdata_p;
    end
    if (re) begin
      rd_data_r <= mem_data_r[raddr];
      rd_prio_r <= mem_prio_r[raddr];
    end
  end

  assign rdata_d = rd_data_r;
  assign rdata_p = rd_prio_r;

endmodule

FILE: rtl/core/spq_ctrl.sv
`include "assert_macros.svh"

module spq_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_cmd,
  input  logic [DATA_WIDTH-1:0]      in_item_data,
  input  logic [PRIO_WIDTH-1:0]      in_item_priority,
  output logic                       in_stall,
  input  logic                       out_free,
  output spq_pkg::spq_res_t          res,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [DATA_WIDTH-1:0]      head_data,
  output logic [PRIO_WIDTH-1:0]      head_prio,
  output logic                       mem_we,
  output logic [$clog2(DEPTH)-1:0]   mem_waddr,
  output logic [DATA_WIDTH-1:0]      mem_wdata_d,
  output logic [PRIO_WIDTH-1:0]      mem_wdata_p,
  output logic                       mem_re,
  output logic [$clog2(DEPTH)-1:0]   mem_raddr,
  input  logic [DATA_WIDTH-1:0]      mem_rdata_d,
  input  logic [PRIO_WIDTH-1:0]      mem_rdata_p
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::spq_state_t  state_r, state_nxt;
  spq_pkg::spq_status_t status_r;
  logic [AW-1:0]         idx_r;
  logic [CW-1:0]         count_r;
  logic [DATA_WIDTH-1:0] new_data_r, head_data_r;
  logic [PRIO_WIDTH-1:0] new_prio_r, head_prio_r;

  logic          prio_lt, prio_eq, move_down, pop_more, wsel_new;
  logic          is_full, is_zero, is_one, is_push;
  logic [AW-1:0] idx_inc, idx_dec;
  logic [CW-1:0] count_dec, count_inc;

  // shared compare and index step
  assign prio_lt   = mem_rdata_p < new_prio_r;
  assign prio_eq   = mem_rdata_p == new_prio_r;
  assign move_down = prio_lt || (prio_eq && (idx_r != '0));
  assign idx_inc   = idx_r + AW'(1);
  assign idx_dec   = idx_r - AW'(1);
  assign count_dec = count_r - CW'(1);
  assign count_inc = count_r + CW'(1);
  assign pop_more  = CW'(idx_r) < count_dec;
  assign is_full   = count_r == CW'(DEPTH);
  assign is_zero   = count_r == '0;
  assign is_one    = count_r == CW'(1);
  assign is_push   = in_cmd == spq_pkg::CMD_PUSH;

  assign mem_wdata_d = wsel_new ? new_data_r : mem_rdata_d;
  assign mem_wdata_p = wsel_new ? new_prio_r : mem_rdata_p;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (is_push) begin
            if (is_full) state_nxt = spq_pkg::S_DONE;
            else if (is_zero) state_nxt = spq_pkg::S_PUSH_HEAD;
            else state_nxt = spq_pkg::S_PUSH_SCAN;
          end else begin
            if (is_zero || is_one) state_nxt = spq_pkg::S_DONE;
            else state_nxt = spq_pkg::S_POP_SCAN;
          end
        end
      end
      spq_pkg::S_PUSH_SCAN: begin
        if (!move_down) state_nxt = spq_pkg::S_DONE;
        else if (idx_r == '0) state_nxt = spq_pkg::S_PUSH_HEAD;
      end
      spq_pkg::S_PUSH_HEAD: state_nxt = spq_pkg::S_DONE;
      spq_pkg::S_POP_SCAN: begin
        if (!pop_more) state_nxt = spq_pkg::S_DONE;
      end
      spq_pkg::S_DONE: begin
        if (out_free) state_nxt = spq_pkg::S_IDLE;
      end
      default: state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    wsel_new   = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    res.done   = 1'b0;
    res.status = status_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && is_push && !is_full && !is_zero) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(count_dec);
        end else if (in_valid && !is_push && !is_zero && !is_one) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(1);
        end
      end
      spq_pkg::S_PUSH_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc;
        wsel_new  = !move_down;
        mem_re    = move_down && (idx_r != '0);
        mem_raddr = idx_dec;
      end
      spq_pkg::S_PUSH_HEAD: begin
        mem_we   = 1'b1;
        wsel_new = 1'b1;
      end
      spq_pkg::S_POP_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_dec;
        mem_re    = pop_more;
        mem_raddr = idx_inc;
      end
      spq_pkg::S_DONE: res.done = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        spq_pkg::S_IDLE: begin
          if (in_valid && !is_push && is_one) count_r <= '0;
        end
        spq_pkg::S_PUSH_SCAN: begin
          if (!move_down) count_r <= count_inc;
        end
        spq_pkg::S_PUSH_HEAD: count_r <= count_inc;
        spq_pkg::S_POP_SCAN: begin
          if (!pop_more) count_r <= count_dec;
        end
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == spq_pkg::S_IDLE && in_valid) begin
      new_data_r <= in_item_data;
      new_prio_r <= in_item_priority;
      idx_r      <= is_push ? AW'(count_dec) : AW'(1);
      if (is_push && is_full) status_r <= spq_pkg::ST_FULL;
      else if (!is_push && is_zero) status_r <= spq_pkg::ST_EMPTY;
      else status_r <= spq_pkg::ST_OK;
    end else if (state_r == spq_pkg::S_PUSH_SCAN && move_down) begin
      idx_r <= idx_dec;
    end else if (state_r == spq_pkg::S_POP_SCAN && pop_more) begin
      idx_r <= idx_inc;
    end
    // mirror slot zero
    if (mem_we && mem_waddr == '0) begin
      head_data_r <= mem_wdata_d;
      head_prio_r <= mem_wdata_p;
    end
  end

  assign count     = count_r;
  assign head_data = head_data_r;
  assign head_prio = head_prio_r;

  `SPQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "count above depth")
  `SPQ_ASSERT_IMPL(a_scan_no_head, clk, rst_n, state_r == spq_pkg::S_PUSH_SCAN, mem_waddr != '0, "scan wrote head")
  `SPQ_ASSERT_IMPL(a_empty_status, clk, rst_n, res.done && res.status == spq_pkg::ST_EMPTY, count_r == '0, "empty status with entries")

endmodule

FILE: rtl/core/sorted_priority_queue_core.sv
// Sorted priority queue, up to DEPTH entries held in descending priority.
// Input channel in_*: one word per command, in_cmd push (with data and
// priority) or pop. A push passes equal-priority entries but not the head.
// Result channel out_*: one word per command with status, head entry,
// empty flag and entry count after the command.
// A push walks the slot memory from the tail, one slot a cycle,
// through a single priority comparator; a pop moves every entry behind
// the head up one slot, one a cycle. A rejected push or a pop of at most
// one entry goes straight to the result with no walk; the longest walk is
// a push to the head of a queue holding DEPTH - 1 entries. The next word
// is taken only once the previous result has entered the output register,
// so commands are handled one at a time. One compare a cycle on a memory
// with one read and one write port sets this pace.
// in_stall stays high from accept until the result enters the output
// register; a new word may be accepted while that result waits.
// While out_stall is high the result holds and the sequencer waits before
// posting the next one. Reset (rst_n low, synchronous) empties the queue;
// slot contents are not cleared.
module sorted_priority_queue_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [DATA_WIDTH-1:0]      in_item_data,
  input  logic [PRIO_WIDTH-1:0]      in_item_priority,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [DATA_WIDTH-1:0]      out_head_data,
  output logic [PRIO_WIDTH-1:0]      out_head_priority,
  output logic                       out_is_empty,
  output logic [$clog2(DEPTH+1)-1:0] out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::spq_res_t     res;
  logic [CW-1:0]         count;
  logic [DATA_WIDTH-1:0] head_data;
  logic [PRIO_WIDTH-1:0] head_prio;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata_d, mem_rdata_d;
  logic [PRIO_WIDTH-1:0] mem_wdata_p, mem_rdata_p;
  logic                  out_free;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            status_r;
  logic [DATA_WIDTH-1:0] head_data_r;
  logic [PRIO_WIDTH-1:0] head_prio_r;
  logic                  empty_r;
  logic [CW-1:0]         count_r;

  spq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_cmd           (in_cmd),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .in_stall         (in_stall),
    .out_free         (out_free),
    .res              (res),
    .count            (count),
    .head_data        (head_data),
    .head_prio        (head_prio),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata_d      (mem_wdata_d),
    .mem_wdata_p      (mem_wdata_p),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata_d      (mem_rdata_d),
    .mem_rdata_p      (mem_rdata_p)
  );

  spq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata_d (mem_wdata_d),
    .wdata_p (mem_wdata_p),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_d (mem_rdata_d),
    .rdata_p (mem_rdata_p)
  );

  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = res.done || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      status_r    <= res.status;
      empty_r     <= count == '0;
      count_r     <= count;
      head_data_r <= (count == '0) ? '0 : head_data;
      head_prio_r <= (count == '0) ? '0 : head_prio;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_head_data     = head_data_r;
  assign out_head_priority = head_prio_r;
  assign out_is_empty      = empty_r;
  assign out_entry_count   = count_r;

endmodule

FILE: verif/sorted_priority_queue_core_tb.sv
module sorted_priority_queue_core_tb;

  localparam int DEPTH = 16;
  localparam int DW = 32;
  localparam int PW = 8;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    spq_pkg::spq_status_t status;
    logic [DW-1:0]        head_data;
    logic [PW-1:0]        head_prio;
    logic                 is_empty;
    logic [CW-1:0]        count;
  } head_view_t;

  class queue_scoreboard;
    logic [DW-1:0] slot_data [DEPTH];
    logic [PW-1:0] slot_prio [DEPTH];
    int unsigned   held;
    head_view_t    owed [$];
    int unsigned   errors, n_push, n_pop, n_refused, n_underflow, n_checked;

    function new();
      held = 0;
      errors = 0;
      n_push = 0;
      n_pop = 0;
      n_refused = 0;
      n_underflow = 0;
      n_checked = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_input(logic cmd, logic [DW-1:0] data, logic [PW-1:0] prio);
      head_view_t  want;
      int unsigned pos;
      want.status = spq_pkg::ST_OK;
      if (cmd == spq_pkg::CMD_PUSH) begin
        n_push++;
        if (held == DEPTH) begin
          want.status = spq_pkg::ST_FULL;
          n_refused++;
        end else begin
          if (held == 0 || prio > slot_prio[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < held && slot_prio[pos] > prio) pos++;
          end
          for (int i = held; i > pos; i--) begin
            slot_data[i] = slot_data[i-1];
            slot_prio[i] = slot_prio[i-1];
          end
          slot_data[pos] = data;
          slot_prio[pos] = prio;
          held++;
        end
      end else begin
        n_pop++;
        if (held == 0) begin
          want.status = spq_pkg::ST_EMPTY;
          n_underflow++;
        end else begin
          for (int i = 0; i + 1 < held; i++) begin
            slot_data[i] = slot_data[i+1];
            slot_prio[i] = slot_prio[i+1];
          end
          held--;
        end
      end
      want.is_empty  = (held == 0);
      want.head_data = (held == 0) ? '0 : slot_data[0];
      want.head_prio = (held == 0) ? '0 : slot_prio[0];
      want.count     = CW'(held);
      owed.push_back(want);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      errors++;
      $display("MISMATCH word %0d %s: got %0h want %0h", n_checked, what, got, want);
    endtask

    task check_result(head_view_t got);
      head_view_t want;
      if (owed.size() == 0) begin
        report_mismatch("result with nothing outstanding", got, 0);
      end else begin
        want = owed.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.head_data !== want.head_data)
          report_mismatch("head_data", got.head_data, want.head_data);
        if (got.head_prio !== want.head_prio)
          report_mismatch("head_priority", got.head_prio, want.head_prio);
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", got.is_empty, want.is_empty);
        if (got.count !== want.count)
          report_mismatch("entry_count", got.count, want.count);
      end
      n_checked++;
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_cmd = spq_pkg::CMD_PUSH;
  logic [DW-1:0] in_item_data = '0;
  logic [PW-1:0] in_item_priority = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    out_status;
  logic [DW-1:0] out_head_data;
  logic [PW-1:0] out_head_priority;
  logic          out_is_empty;
  logic [CW-1:0] out_entry_count;

  queue_scoreboard sb;
  bit              calm = 1'b0;
  int              stall_left = 0;
  int unsigned     cycles = 0;

  sorted_priority_queue_core #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DW),
    .PRIO_WIDTH(PW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_item_data(in_item_data),
    .in_item_priority(in_item_priority),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_head_data(out_head_data),
    .out_head_priority(out_head_priority),
    .out_is_empty(out_is_empty),
    .out_entry_count(out_entry_count)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (calm) begin
      out_stall <= 1'b0;
      stall_left = 4;
    end else begin
      out_stall <= ($urandom_range(0, 1) == 1);
      stall_left = 1 + pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(head_view_t'{status: spq_pkg::spq_status_t'(out_status),
                                   head_data: out_head_data,
                                   head_prio: out_head_priority,
                                   is_empty: out_is_empty,
                                   count: out_entry_count});
  end

  task send_word(logic cmd, logic [DW-1:0] data, logic [PW-1:0] prio);
    int gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_item_data <= data;
    in_item_priority <= prio;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, data, prio);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int            bias;
    int            pmode;
    int            push_pct;
    logic          cmd;
    logic [PW-1:0] prio;
    logic [PW-1:0] fill_prio [12];
    fill_prio = '{8'h80, 8'h80, 8'h01, 8'hfe, 8'h80, 8'h7f,
                  8'h01, 8'h80, 8'hff, 8'h00, 8'h40, 8'h80};
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(spq_pkg::CMD_POP, '1, '1);
    send_word(spq_pkg::CMD_PUSH, '0, '0);
    send_word(spq_pkg::CMD_PUSH, '1, '1);
    send_word(spq_pkg::CMD_PUSH, 32'h5a5a_a5a5, '1);
    send_word(spq_pkg::CMD_PUSH, 32'h0000_0001, '0);
    foreach (fill_prio[i]) send_word(spq_pkg::CMD_PUSH, $urandom, fill_prio[i]);
    send_word(spq_pkg::CMD_PUSH, $urandom, 8'hff);
    repeat (3) send_word(spq_pkg::CMD_POP, $urandom, PW'($urandom));
    drain();

    for (int ph = 0; ph < 24; ph++) begin
      bias  = $urandom_range(0, 2);
      pmode = $urandom_range(0, 3);
      calm  = (ph % 4 == 3);
      push_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
      for (int k = 0; k < 50; k++) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP;
        case (pmode)
          0: prio = PW'($urandom_range(0, 255));
          1: prio = PW'($urandom_range(0, 3));
          2: prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
          default: prio = $urandom_range(0, 1) ? PW'($urandom_range(250, 255))
                                               : PW'($urandom_range(0, 5));
        endcase
        send_word(cmd, $urandom, prio);
      end
      if (ph % 5 == 4) drain();
    end
    calm = 1'b0;

    drain();
    repeat (DEPTH + 4) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch("results never arrived", 0, sb.pending());

    $display("Covered %0d pushes (%0d refused on a full queue) and %0d pops",
             sb.n_push, sb.n_refused, sb.n_pop);
    $display("(%0d on an empty queue); %0d result words compared, %0d mismatches.",
             sb.n_underflow, sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
